### sv/srtt_sel_pkg.sv
// shared types and constants of the smoothed rtt server selector
// used by srtt_sel_ctl, srtt_sel_dp and smoothed_rtt_server_selector_unit
`default_nettype none

package srtt_sel_pkg;

    localparam int NUM_SLOTS      = 4;
    localparam int SLOT_W         = 2;
    localparam int IP_W           = 32;
    localparam int PORT_W         = 16;
    localparam int RTT_W          = 16;
    localparam int TICK_W         = 32;
    localparam int PCT_W          = 7;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int SRTT_W         = 24;
    localparam int SRTT_FRAC_BITS = 3;
    localparam int BETA_OLD       = 7;
    localparam int BETA_NEW       = 1;
    localparam int BETA_TOTAL     = 8;
    localparam int BETA_SHIFT     = $clog2(BETA_TOTAL);
    localparam int PCT_SCALE      = 100;

    localparam int CUR_W  = SRTT_W - SRTT_FRAC_BITS;
    localparam int BEST_W = RTT_W + SRTT_FRAC_BITS;
    localparam int LHS_W  = CUR_W + 9;
    localparam int RHS_W  = PCT_W + CUR_W;
    localparam int EW_W   = SRTT_W + 10;

    localparam logic [RTT_W-1:0]  RTT_LIMIT_RST     = RTT_W'(250);
    localparam logic [TICK_W-1:0] STALL_TIMEOUT_RST = TICK_W'(1000);
    localparam logic [PCT_W-1:0]  SWITCH_PCT_RST    = '0;
    localparam logic [RTT_W-1:0]  SWITCH_MARGIN_RST = '0;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SAMPLE = 3'd2,
        OP_SET    = 3'd3,
        OP_EVAL   = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_IGNORED   = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_REFUSED   = 3'd3,
        STAT_NO_ACTIVE = 3'd4,
        STAT_EMERGENCY = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RTT_LIMIT     = 2'd0,
        CFG_STALL_TIMEOUT = 2'd1,
        CFG_SWITCH_PCT    = 2'd2,
        CFG_SWITCH_MARGIN = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MULT,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              load;
        logic              exec;
        logic              scan;
        logic [SLOT_W-1:0] scan_idx;
        logic              mult;
        logic              decide;
    } t_ctl_cmd;

    typedef struct packed {
        logic eval_go;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/smoothed_rtt_server_selector_unit.sv
// top level of the smoothed rtt server selector: controller plus datapath
// depends on srtt_sel_pkg, srtt_sel_ctl and srtt_sel_dp
//
// A command beat is taken when start is high and busy is low; its result
// appears on the o_ result ports for exactly one cycle with o_done high and
// cannot be held off, so the receiver must take it then. Add, remove, rtt
// sample, set active and unknown opcodes go from the execute state
// straight to the done state. Evaluate goes through execute, then the
// controller scans the four table slots one per cycle through the single
// table read port, then uses the multiply state for the percent products
// and the decide state for the switch decision. An evaluate that finds no
// active server or ends in an emergency skips the scan and goes straight
// to done. A new beat is taken only once back in idle. Configuration writes
// go straight into the config registers and should be issued while busy is low.
`default_nettype none

module smoothed_rtt_server_selector_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    output logic                            o_done,
    input  wire                             i_cfg_we,
    input  wire [srtt_sel_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [srtt_sel_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire [2:0]                       i_opcode,
    input  wire [srtt_sel_pkg::SLOT_W-1:0]  i_server_slot,
    input  wire [srtt_sel_pkg::IP_W-1:0]    i_ip_addr,
    input  wire [srtt_sel_pkg::PORT_W-1:0]  i_port_num,
    input  wire [srtt_sel_pkg::RTT_W-1:0]   i_rtt_sample,
    input  wire                             i_sample_kind,
    input  wire [srtt_sel_pkg::TICK_W-1:0]  i_now_tick,
    input  wire                             i_pending,
    output logic [2:0]                      o_status,
    output logic [srtt_sel_pkg::SLOT_W-1:0] o_used_slot,
    output logic [srtt_sel_pkg::SLOT_W-1:0] o_active_slot,
    output logic                            o_active_valid,
    output logic                            o_switched,
    output logic                            o_failed_over,
    output logic [srtt_sel_pkg::RTT_W-1:0]  o_fastest_rtt
);

    srtt_sel_pkg::t_ctl_cmd cmd;
    srtt_sel_pkg::t_dp_stat stat;

    srtt_sel_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    srtt_sel_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_server_slot  (i_server_slot),
        .i_ip_addr      (i_ip_addr),
        .i_port_num     (i_port_num),
        .i_rtt_sample   (i_rtt_sample),
        .i_sample_kind  (i_sample_kind),
        .i_now_tick     (i_now_tick),
        .i_pending      (i_pending),
        .o_status       (o_status),
        .o_used_slot    (o_used_slot),
        .o_active_slot  (o_active_slot),
        .o_active_valid (o_active_valid),
        .o_switched     (o_switched),
        .o_failed_over  (o_failed_over),
        .o_fastest_rtt  (o_fastest_rtt)
    );

endmodule

`default_nettype wire

### sv/srtt_sel_ctl.sv
// sequencing controller of the server selector
// depends on srtt_sel_pkg; drives srtt_sel_dp through t_ctl_cmd
`default_nettype none

module srtt_sel_ctl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    input  srtt_sel_pkg::t_dp_stat i_stat,
    output srtt_sel_pkg::t_ctl_cmd o_cmd,
    output logic                  busy,
    output logic                  o_done
);

    srtt_sel_pkg::t_state r_state;
    srtt_sel_pkg::t_state n_state;
    logic [srtt_sel_pkg::SLOT_W-1:0] r_scan_idx;
    logic [srtt_sel_pkg::SLOT_W-1:0] n_scan_idx;
    logic scan_last;

    assign scan_last = (r_scan_idx == srtt_sel_pkg::SLOT_W'(srtt_sel_pkg::NUM_SLOTS - 1));

    always_comb begin
        n_state    = r_state;
        n_scan_idx = r_scan_idx;
        unique case (r_state)
            srtt_sel_pkg::S_IDLE: begin
                if (start) begin
                    n_state = srtt_sel_pkg::S_EXEC;
                end
            end
            srtt_sel_pkg::S_EXEC: begin
                n_scan_idx = '0;
                if (i_stat.eval_go) begin
                    n_state = srtt_sel_pkg::S_SCAN;
                end else begin
                    n_state = srtt_sel_pkg::S_DONE;
                end
            end
            srtt_sel_pkg::S_SCAN: begin
                n_scan_idx = r_scan_idx + 1'b1;
                if (scan_last) begin
                    n_state = srtt_sel_pkg::S_MULT;
                end
            end
            srtt_sel_pkg::S_MULT:   n_state = srtt_sel_pkg::S_DECIDE;
            srtt_sel_pkg::S_DECIDE: n_state = srtt_sel_pkg::S_DONE;
            srtt_sel_pkg::S_DONE:   n_state = srtt_sel_pkg::S_IDLE;
            default:                n_state = srtt_sel_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.scan_idx = r_scan_idx;
        busy           = 1'b1;
        o_done         = 1'b0;
        unique case (r_state)
            srtt_sel_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            srtt_sel_pkg::S_EXEC:   o_cmd.exec   = 1'b1;
            srtt_sel_pkg::S_SCAN:   o_cmd.scan   = 1'b1;
            srtt_sel_pkg::S_MULT:   o_cmd.mult   = 1'b1;
            srtt_sel_pkg::S_DECIDE: o_cmd.decide = 1'b1;
            srtt_sel_pkg::S_DONE:   o_done       = 1'b1;
            default:                busy         = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= srtt_sel_pkg::S_IDLE;
            r_scan_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
        end
    end

endmodule

`default_nettype wire

### sv/srtt_sel_dp.sv
// datapath of the server selector: server table, config registers, scan and switch logic
// depends on srtt_sel_pkg; commanded by srtt_sel_ctl
`default_nettype none

module srtt_sel_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  srtt_sel_pkg::t_ctl_cmd               i_cmd,
    output srtt_sel_pkg::t_dp_stat               o_stat,
    input  wire                                  i_cfg_we,
    input  wire [srtt_sel_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [srtt_sel_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire [2:0]                            i_opcode,
    input  wire [srtt_sel_pkg::SLOT_W-1:0]       i_server_slot,
    input  wire [srtt_sel_pkg::IP_W-1:0]         i_ip_addr,
    input  wire [srtt_sel_pkg::PORT_W-1:0]       i_port_num,
    input  wire [srtt_sel_pkg::RTT_W-1:0]        i_rtt_sample,
    input  wire                                  i_sample_kind,
    input  wire [srtt_sel_pkg::TICK_W-1:0]       i_now_tick,
    input  wire                                  i_pending,
    output logic [2:0]                           o_status,
    output logic [srtt_sel_pkg::SLOT_W-1:0]      o_used_slot,
    output logic [srtt_sel_pkg::SLOT_W-1:0]      o_active_slot,
    output logic                                 o_active_valid,
    output logic                                 o_switched,
    output logic                                 o_failed_over,
    output logic [srtt_sel_pkg::RTT_W-1:0]       o_fastest_rtt
);

    localparam int N  = srtt_sel_pkg::NUM_SLOTS;
    localparam int SW = srtt_sel_pkg::SLOT_W;
    localparam int F  = srtt_sel_pkg::SRTT_FRAC_BITS;

    // config
    logic [srtt_sel_pkg::RTT_W-1:0]  r_rtt_limit;
    logic [srtt_sel_pkg::TICK_W-1:0] r_stall_timeout;
    logic [srtt_sel_pkg::PCT_W-1:0]  r_switch_pct;
    logic [srtt_sel_pkg::RTT_W-1:0]  r_switch_margin;

    // captured beat
    srtt_sel_pkg::t_opcode           r_op;
    logic [SW-1:0]                   r_slot;
    logic [srtt_sel_pkg::IP_W-1:0]   r_ip;
    logic [srtt_sel_pkg::PORT_W-1:0] r_port;
    logic [srtt_sel_pkg::RTT_W-1:0]  r_rtt;
    logic                            r_kind;
    logic [srtt_sel_pkg::TICK_W-1:0] r_now;
    logic                            r_pend;

    // server table
    logic [N-1:0]                    r_valid;
    logic [srtt_sel_pkg::IP_W-1:0]   r_tab_ip   [N];
    logic [srtt_sel_pkg::PORT_W-1:0] r_tab_port [N];
    logic [srtt_sel_pkg::SRTT_W-1:0] r_tab_srtt [N];
    logic [srtt_sel_pkg::RTT_W-1:0]  r_tab_min  [N];
    logic [srtt_sel_pkg::TICK_W-1:0] r_tab_last [N];
    logic [SW-1:0]                   r_act_idx;
    logic                            r_act_present;

    // results and evaluate work registers
    srtt_sel_pkg::t_status           r_status;
    logic [SW-1:0]                   r_used;
    logic                            r_sw;
    logic                            r_fo;
    logic [srtt_sel_pkg::RTT_W-1:0]  r_fast;
    logic [srtt_sel_pkg::BEST_W-1:0] r_best;
    logic [SW-1:0]                   r_alt_idx;
    logic                            r_alt_found;
    logic [srtt_sel_pkg::CUR_W-1:0]  r_cur;
    logic [srtt_sel_pkg::LHS_W-1:0]  r_lhs;
    logic [srtt_sel_pkg::RHS_W-1:0]  r_rhs;

    srtt_sel_pkg::t_status           n_status;
    logic [SW-1:0]                   rd_idx;
    logic [srtt_sel_pkg::SRTT_W-1:0] rd_srtt;
    logic [srtt_sel_pkg::RTT_W-1:0]  rd_min;
    logic [srtt_sel_pkg::TICK_W-1:0] rd_last;
    logic                            slot_vld;
    logic                            dup_hit;
    logic                            free_found;
    logic [SW-1:0]                   free_idx;
    logic                            nx_found;
    logic [SW-1:0]                   nx_idx;
    logic [srtt_sel_pkg::RTT_W-1:0]  rtt_c;
    logic                            smp_keep;
    logic [srtt_sel_pkg::SRTT_W-1:0] srtt_new;
    logic [srtt_sel_pkg::EW_W-1:0]   ewma;
    logic                            act_ok;
    logic                            stalled;
    logic                            add_do;
    logic                            rm_do;
    logic                            smp_do;
    logic                            set_do;
    logic                            fail_do;
    logic                            scan_hit;
    logic [srtt_sel_pkg::RTT_W-1:0]  mn;
    logic [srtt_sel_pkg::CUR_W:0]    diff;
    logic [srtt_sel_pkg::LHS_W-1:0]  diff_ext;
    logic                            pct_block;
    logic                            mar_block;
    logic                            switch_do;

    assign rd_idx   = i_cmd.scan ? i_cmd.scan_idx
                    : ((r_op == srtt_sel_pkg::OP_EVAL) ? r_act_idx : r_slot);
    assign rd_srtt  = r_tab_srtt[rd_idx];
    assign rd_min   = r_tab_min[rd_idx];
    assign rd_last  = r_tab_last[rd_idx];
    assign slot_vld = r_valid[r_slot];
    assign act_ok   = r_act_present && r_valid[r_act_idx];
    assign stalled  = r_pend && ((r_now - rd_last) > r_stall_timeout);
    assign rtt_c    = (r_rtt == '0) ? srtt_sel_pkg::RTT_W'(1) : r_rtt;
    assign smp_keep = (rtt_c <= r_rtt_limit);

    always_comb begin
        dup_hit    = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        nx_found   = 1'b0;
        nx_idx     = '0;
        for (int s = N - 1; s >= 0; s--) begin
            if (r_valid[s] && (r_tab_ip[s] == r_ip) && (r_tab_port[s] == r_port)) begin
                dup_hit = 1'b1;
            end
            if (!r_valid[s]) begin
                free_found = 1'b1;
                free_idx   = SW'(s);
            end
            if (r_valid[s] && (SW'(s) != r_act_idx)) begin
                nx_found = 1'b1;
                nx_idx   = SW'(s);
            end
        end
    end

    // ewma of the smoothed rtt, or a reseed
    always_comb begin
        ewma = (srtt_sel_pkg::EW_W'(srtt_sel_pkg::BETA_OLD) * srtt_sel_pkg::EW_W'(rd_srtt)
              + ((srtt_sel_pkg::EW_W'(srtt_sel_pkg::BETA_NEW) * srtt_sel_pkg::EW_W'(rtt_c)) << F))
              >> srtt_sel_pkg::BETA_SHIFT;
        if ((rd_srtt == '0) || r_kind) begin
            srtt_new = srtt_sel_pkg::SRTT_W'(srtt_sel_pkg::SRTT_W'(rtt_c) << F);
        end else begin
            srtt_new = ewma[srtt_sel_pkg::SRTT_W-1:0];
        end
    end

    always_comb begin
        add_do   = 1'b0;
        rm_do    = 1'b0;
        smp_do   = 1'b0;
        set_do   = 1'b0;
        fail_do  = 1'b0;
        n_status = srtt_sel_pkg::STAT_IGNORED;
        o_stat.eval_go = 1'b0;
        unique case (r_op)
            srtt_sel_pkg::OP_ADD: begin
                priority if (dup_hit) begin
                    n_status = srtt_sel_pkg::STAT_IGNORED;
                end else if (!free_found) begin
                    n_status = srtt_sel_pkg::STAT_FULL;
                end else if ((r_ip == '0) || (r_port == '0)) begin
                    n_status = srtt_sel_pkg::STAT_REFUSED;
                end else begin
                    n_status = srtt_sel_pkg::STAT_OK;
                    add_do   = 1'b1;
                end
            end
            srtt_sel_pkg::OP_REMOVE: begin
                priority if (!slot_vld) begin
                    n_status = srtt_sel_pkg::STAT_IGNORED;
                end else if (r_act_present && (r_act_idx == r_slot)) begin
                    n_status = srtt_sel_pkg::STAT_REFUSED;
                end else begin
                    n_status = srtt_sel_pkg::STAT_OK;
                    rm_do    = 1'b1;
                end
            end
            srtt_sel_pkg::OP_SAMPLE: begin
                smp_do = slot_vld;
                if (slot_vld && smp_keep) begin
                    n_status = srtt_sel_pkg::STAT_OK;
                end
            end
            srtt_sel_pkg::OP_SET: begin
                set_do = slot_vld;
                if (slot_vld) begin
                    n_status = srtt_sel_pkg::STAT_OK;
                end
            end
            srtt_sel_pkg::OP_EVAL: begin
                priority if (!act_ok) begin
                    n_status = srtt_sel_pkg::STAT_NO_ACTIVE;
                end else if (stalled && !nx_found) begin
                    n_status = srtt_sel_pkg::STAT_EMERGENCY;
                end else begin
                    n_status       = srtt_sel_pkg::STAT_OK;
                    fail_do        = stalled;
                    o_stat.eval_go = 1'b1;
                end
            end
            default: n_status = srtt_sel_pkg::STAT_IGNORED;
        endcase
    end

    assign scan_hit = r_valid[i_cmd.scan_idx]
                   && (rd_srtt < srtt_sel_pkg::SRTT_W'(r_best))
                   && (rd_min < r_rtt_limit);

    assign mn       = r_best[srtt_sel_pkg::BEST_W-1:F];
    assign diff     = {1'b0, r_cur} - (srtt_sel_pkg::CUR_W + 1)'(mn);
    assign diff_ext = {{(srtt_sel_pkg::LHS_W - srtt_sel_pkg::CUR_W - 1){diff[srtt_sel_pkg::CUR_W]}},
                       diff};

    assign pct_block = (r_switch_pct != '0)
                    && ($signed(r_lhs) < $signed(srtt_sel_pkg::LHS_W'(r_rhs)));
    assign mar_block = (r_switch_margin != '0)
                    && ((srtt_sel_pkg::CUR_W + 1)'(r_fast) + (srtt_sel_pkg::CUR_W + 1)'(r_switch_margin)
                        > (srtt_sel_pkg::CUR_W + 1)'(r_cur));
    assign switch_do = r_alt_found && (r_alt_idx != r_act_idx) && !pct_block && !mar_block
                    && ((r_switch_pct != '0) || (r_switch_margin != '0));

    // control state: config, valid bits, active pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rtt_limit     <= srtt_sel_pkg::RTT_LIMIT_RST;
            r_stall_timeout <= srtt_sel_pkg::STALL_TIMEOUT_RST;
            r_switch_pct    <= srtt_sel_pkg::SWITCH_PCT_RST;
            r_switch_margin <= srtt_sel_pkg::SWITCH_MARGIN_RST;
            r_valid         <= '0;
            r_act_idx       <= '0;
            r_act_present   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (srtt_sel_pkg::t_cfg_idx'(i_cfg_idx))
                    srtt_sel_pkg::CFG_RTT_LIMIT:
                        r_rtt_limit <= i_cfg_data[srtt_sel_pkg::RTT_W-1:0];
                    srtt_sel_pkg::CFG_STALL_TIMEOUT:
                        r_stall_timeout <= i_cfg_data[srtt_sel_pkg::TICK_W-1:0];
                    srtt_sel_pkg::CFG_SWITCH_PCT:
                        r_switch_pct <= i_cfg_data[srtt_sel_pkg::PCT_W-1:0];
                    srtt_sel_pkg::CFG_SWITCH_MARGIN:
                        r_switch_margin <= i_cfg_data[srtt_sel_pkg::RTT_W-1:0];
                    default: r_rtt_limit <= r_rtt_limit;
                endcase
            end
            if (i_cmd.exec) begin
                if (add_do) begin
                    r_valid[free_idx] <= 1'b1;
                end
                if (rm_do) begin
                    r_valid[r_slot] <= 1'b0;
                end
                if (set_do) begin
                    r_act_idx     <= r_slot;
                    r_act_present <= 1'b1;
                end
                if (fail_do) begin
                    r_valid[r_act_idx] <= 1'b0;
                    r_act_idx          <= nx_idx;
                end
            end
            if (i_cmd.decide && switch_do) begin
                r_act_idx <= r_alt_idx;
            end
        end
    end

    // payload: beat capture, table contents, results, evaluate work
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= srtt_sel_pkg::t_opcode'(i_opcode);
            r_slot   <= i_server_slot;
            r_ip     <= i_ip_addr;
            r_port   <= i_port_num;
            r_rtt    <= i_rtt_sample;
            r_kind   <= i_sample_kind;
            r_now    <= i_now_tick;
            r_pend   <= i_pending;
            r_status <= srtt_sel_pkg::STAT_IGNORED;
            r_used   <= '0;
            r_sw     <= 1'b0;
            r_fo     <= 1'b0;
            r_fast   <= '0;
        end
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_best      <= srtt_sel_pkg::BEST_W'(srtt_sel_pkg::BEST_W'(r_rtt_limit) << F);
            r_alt_found <= 1'b0;
            r_alt_idx   <= '0;
            r_cur       <= '0;
            if (add_do) begin
                r_tab_ip[free_idx]   <= r_ip;
                r_tab_port[free_idx] <= r_port;
                r_tab_srtt[free_idx] <= '0;
                r_tab_min[free_idx]  <= r_rtt_limit;
                r_tab_last[free_idx] <= '0;
                r_used               <= free_idx;
            end
            if (smp_do) begin
                r_tab_last[r_slot] <= r_now;
                if (smp_keep) begin
                    if (rtt_c < rd_min) begin
                        r_tab_min[r_slot] <= rtt_c;
                    end
                    r_tab_srtt[r_slot] <= srtt_new;
                end
            end
            if (fail_do) begin
                r_sw <= 1'b1;
                r_fo <= 1'b1;
            end
        end
        if (i_cmd.scan) begin
            if (scan_hit) begin
                r_best      <= rd_srtt[srtt_sel_pkg::BEST_W-1:0];
                r_alt_idx   <= i_cmd.scan_idx;
                r_alt_found <= 1'b1;
            end
            if (i_cmd.scan_idx == r_act_idx) begin
                r_cur <= rd_srtt[srtt_sel_pkg::SRTT_W-1:F];
            end
        end
        if (i_cmd.mult) begin
            r_fast <= mn;
            r_lhs  <= diff_ext * srtt_sel_pkg::LHS_W'(srtt_sel_pkg::PCT_SCALE);
            r_rhs  <= srtt_sel_pkg::RHS_W'(r_switch_pct) * srtt_sel_pkg::RHS_W'(r_cur);
        end
        if (i_cmd.decide && switch_do) begin
            r_sw <= 1'b1;
        end
    end

    assign o_status       = r_status;
    assign o_used_slot    = r_used;
    assign o_active_slot  = r_act_present ? r_act_idx : '0;
    assign o_active_valid = r_act_present;
    assign o_switched     = r_sw;
    assign o_failed_over  = r_fo;
    assign o_fastest_rtt  = r_fast;

endmodule

`default_nettype wire
